// File: design/drtm_pkg.sv
// ----------------------------------------------------------------------------
// drtm_pkg: shared types and codes of the dirty rectangle tracker
// Holds the action and status codes and the control part of a queued command.
// ----------------------------------------------------------------------------
package drtm_pkg;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_MERGE = 2'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_COVERED = 3'd1;
    localparam logic [2:0] ST_OFF     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;
    localparam logic [2:0] ST_LISTED  = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    // Control part of a command; it sits in the low bits of a queue entry.
    typedef struct packed {
        logic       off;
        logic [1:0] action;
    } t_cmd_ctl;

    localparam int CTL_W = $bits(t_cmd_ctl);

endpackage

// File: design/drtm_front.sv
// ----------------------------------------------------------------------------
// drtm_front: command classifier
// Clips an add rectangle to the screen and flags rectangles that fall off it.
// ----------------------------------------------------------------------------
module drtm_front import drtm_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic [1:0]            i_action,
    input  logic [15:0]           i_left,
    input  logic [15:0]           i_top,
    input  logic [15:0]           i_right,
    input  logic [15:0]           i_bottom,
    input  logic [12:0]           i_screen_width,
    input  logic [12:0]           i_screen_height,
    output logic [6*COORD_BITS+CTL_W-1:0] o_cmd
);

    localparam int SW = 18;
    localparam logic [SW-1:0] LIM = SW'(2**COORD_BITS);

    logic [SW-1:0] w, h;
    logic signed [SW-1:0] sx2, sy2, l, t, r, b, cx1, cy1, cx2, cy2;
    t_cmd_ctl ctl;

    always_comb begin
        w   = ({5'd0, i_screen_width} > LIM) ? LIM : {5'd0, i_screen_width};
        h   = ({5'd0, i_screen_height} > LIM) ? LIM : {5'd0, i_screen_height};
        sx2 = $signed(w) - 18'sd1;
        sy2 = $signed(h) - 18'sd1;
        l   = {{2{i_left[15]}}, i_left};
        t   = {{2{i_top[15]}}, i_top};
        r   = {{2{i_right[15]}}, i_right};
        b   = {{2{i_bottom[15]}}, i_bottom};
        cx1 = l[SW-1] ? '0 : l;
        cy1 = t[SW-1] ? '0 : t;
        cx2 = (r < sx2) ? r : sx2;
        cy2 = (b < sy2) ? b : sy2;
        ctl.action = i_action;
        ctl.off    = (cx1 > cx2) || (cy1 > cy2);
        o_cmd = {sx2[COORD_BITS-1:0], sy2[COORD_BITS-1:0],
                 cx1[COORD_BITS-1:0], cy1[COORD_BITS-1:0],
                 cx2[COORD_BITS-1:0], cy2[COORD_BITS-1:0], ctl};
    end

endmodule

// File: design/drtm_queue.sv
// ----------------------------------------------------------------------------
// drtm_queue: two-entry command queue
// Decouples the classifier from the table sequencer.
// ----------------------------------------------------------------------------
module drtm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: design/drtm_back.sv
// ----------------------------------------------------------------------------
// drtm_back: table sequencer
// Runs coverage scans, appends, clears and the pairwise merge and list pass.
// ----------------------------------------------------------------------------
module drtm_back import drtm_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12,
    parameter int CNT_W       = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic [6*COORD_BITS+CTL_W-1:0] i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [CNT_W-1:0]              o_count,
    output logic [4*COORD_BITS-1:0]       o_rect,
    output logic                          o_last
);

    localparam int CB = COORD_BITS;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RW = 4 * CB;
    localparam int AW = 2 * (CB + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ARD  = 4'd1;
    localparam logic [3:0] S_AWT  = 4'd2;
    localparam logic [3:0] S_ACHK = 4'd3;
    localparam logic [3:0] S_MI   = 4'd4;
    localparam logic [3:0] S_MIW  = 4'd5;
    localparam logic [3:0] S_MIL  = 4'd6;
    localparam logic [3:0] S_MJ   = 4'd7;
    localparam logic [3:0] S_MJW  = 4'd8;
    localparam logic [3:0] S_MJC  = 4'd9;
    localparam logic [3:0] S_MJU  = 4'd10;
    localparam logic [3:0] S_LRD  = 4'd11;
    localparam logic [3:0] S_LWT  = 4'd12;
    localparam logic [3:0] S_LGO  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [RW-1:0] r_mem [TABLE_DEPTH];
    logic [RW-1:0] r_rdata;
    logic [IW-1:0] r_addr, n_addr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [RW-1:0] wdata;

    logic [3:0]             r_state, n_state, r_ret, n_ret;
    logic [CNT_W-1:0]       r_count, n_count, r_i, n_i, r_j, n_j;
    logic [TABLE_DEPTH-1:0] r_merged, n_merged;
    logic [RW-1:0]          r_c, n_c, r_scr, n_scr, r_d, n_d, r_m, n_m;
    logic [AW-1:0]          r_ad, n_ad, r_am, n_am, r_as, n_as;
    logic                   r_touch, n_touch;
    logic [2:0]             r_pst, n_pst;
    logic [RW-1:0]          r_prect, n_prect;
    logic                   r_plast, n_plast;
    logic                   r_ovalid, n_ovalid;
    logic [2:0]             r_ost, n_ost;
    logic [CNT_W-1:0]       r_ocnt, n_ocnt;
    logic [RW-1:0]          r_orect, n_orect;
    logic                   r_olast, n_olast;

    t_cmd_ctl ctl;
    logic [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, mx1, my1, mx2, my2;
    logic          later;

    assign o_valid  = r_ovalid;
    assign o_status = r_ost;
    assign o_count  = r_ocnt;
    assign o_rect   = r_orect;
    assign o_last   = r_olast;

    function automatic logic [AW-1:0] area(input logic [RW-1:0] rc);
        logic [CB:0] wd, ht;
        wd = {1'b0, rc[2*CB-1:CB]} - {1'b0, rc[4*CB-1:3*CB]} + (CB+1)'(1);
        ht = {1'b0, rc[CB-1:0]} - {1'b0, rc[3*CB-1:2*CB]} + (CB+1)'(1);
        return wd * ht;
    endfunction

    // Rectangles are packed {x1, y1, x2, y2}, x1 highest.
    always_comb begin
        {ax1, ay1, ax2, ay2} = r_d;
        {bx1, by1, bx2, by2} = r_rdata;
        mx1 = (ax1 < bx1) ? ax1 : bx1;
        my1 = (ay1 < by1) ? ay1 : by1;
        mx2 = (ax2 > bx2) ? ax2 : bx2;
        my2 = (ay2 > by2) ? ay2 : by2;
        later = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (CNT_W'(k) > r_i && CNT_W'(k) < r_count && !r_merged[k]) later = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_count = r_count;
        n_i = r_i;  n_j = r_j;  n_merged = r_merged;  n_addr = r_addr;
        n_c = r_c;  n_scr = r_scr;  n_d = r_d;  n_m = r_m;
        n_ad = r_ad;  n_am = r_am;  n_as = r_as;  n_touch = r_touch;
        n_pst = r_pst;  n_prect = r_prect;  n_plast = r_plast;
        n_ovalid = r_ovalid;  n_ost = r_ost;  n_ocnt = r_ocnt;
        n_orect = r_orect;  n_olast = r_olast;
        we = 1'b0;  waddr = r_i[IW-1:0];  wdata = r_c;
        o_cmd_pop = 1'b0;
        ctl = i_cmd[CTL_W-1:0];

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_c   = i_cmd[CTL_W +: RW];
                    n_scr = {{2*CB{1'b0}}, i_cmd[CTL_W+RW +: 2*CB]};
                    n_i   = '0;
                    n_prect = '0;
                    n_plast = 1'b1;
                    n_ret   = S_IDLE;
                    case (ctl.action)
                        ACT_ADD: begin
                            if (ctl.off) begin
                                n_pst = ST_OFF;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_ARD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_merged = '0;
                            n_pst = ST_CLEARED;
                            n_state = S_OUT;
                        end
                        ACT_MERGE: begin
                            n_merged = '0;
                            if (r_count == '0) begin
                                n_pst = ST_EMPTY;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_MI;
                            end
                        end
                        default: begin
                            n_pst = ST_EMPTY;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_ARD: begin
                if (r_i < r_count) begin
                    n_addr = r_i[IW-1:0];
                    n_state = S_AWT;
                end else if (r_count < DEPTH) begin
                    we = 1'b1;
                    waddr = r_count[IW-1:0];
                    wdata = r_c;
                    n_count = r_count + CNT_W'(1);
                    n_pst = ST_ADDED;
                    n_prect = r_c;
                    n_state = S_OUT;
                end else begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = r_scr;
                    n_count = CNT_W'(1);
                    n_pst = ST_FULL;
                    n_prect = r_scr;
                    n_state = S_OUT;
                end
            end
            S_AWT: n_state = S_ACHK;
            S_ACHK: begin
                if (r_c[4*CB-1:3*CB] >= r_rdata[4*CB-1:3*CB]
                    && r_c[3*CB-1:2*CB] >= r_rdata[3*CB-1:2*CB]
                    && r_c[2*CB-1:CB] <= r_rdata[2*CB-1:CB]
                    && r_c[CB-1:0] <= r_rdata[CB-1:0]) begin
                    n_pst = ST_COVERED;
                    n_prect = r_c;
                    n_state = S_OUT;
                end else begin
                    n_i = r_i + CNT_W'(1);
                    n_state = S_ARD;
                end
            end
            S_MI: begin
                if (r_i >= r_count) begin
                    n_i = '0;
                    n_state = S_LRD;
                end else if (r_merged[r_i[IW-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_addr = r_i[IW-1:0];
                    n_state = S_MIW;
                end
            end
            S_MIW: n_state = S_MIL;
            S_MIL: begin
                n_d = r_rdata;
                n_ad = area(r_rdata);
                n_j = '0;
                n_state = S_MJ;
            end
            S_MJ: begin
                if (r_j >= r_count) begin
                    we = 1'b1;
                    waddr = r_i[IW-1:0];
                    wdata = r_d;
                    n_i = r_i + CNT_W'(1);
                    n_state = S_MI;
                end else if (r_merged[r_j[IW-1:0]] || r_j == r_i) begin
                    n_j = r_j + CNT_W'(1);
                end else begin
                    n_addr = r_j[IW-1:0];
                    n_state = S_MJW;
                end
            end
            S_MJW: n_state = S_MJC;
            S_MJC: begin
                // Overlapping or touching: each side may be one column away.
                n_touch = ({1'b0, ax1} <= {1'b0, bx2} + (CB+1)'(1))
                       && ({1'b0, ax2} + (CB+1)'(1) >= {1'b0, bx1})
                       && ({1'b0, ay1} <= {1'b0, by2} + (CB+1)'(1))
                       && ({1'b0, ay2} + (CB+1)'(1) >= {1'b0, by1});
                n_m  = {mx1, my1, mx2, my2};
                n_am = area({mx1, my1, mx2, my2});
                n_as = area(r_rdata);
                n_state = S_MJU;
            end
            S_MJU: begin
                if (r_touch && {1'b0, r_am} < {1'b0, r_ad} + {1'b0, r_as}) begin
                    n_d = r_m;
                    n_ad = r_am;
                    n_merged[r_j[IW-1:0]] = 1'b1;
                end
                n_j = r_j + CNT_W'(1);
                n_state = S_MJ;
            end
            S_LRD: begin
                if (r_i >= r_count) begin
                    n_state = S_IDLE;
                end else if (r_merged[r_i[IW-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_addr = r_i[IW-1:0];
                    n_state = S_LWT;
                end
            end
            S_LWT: n_state = S_LGO;
            S_LGO: begin
                n_pst = ST_LISTED;
                n_prect = r_rdata;
                n_plast = !later;
                n_ret = later ? S_LRD : S_IDLE;
                n_i = r_i + CNT_W'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ost = r_pst;
                    n_ocnt = r_count;
                    n_orect = r_prect;
                    n_olast = r_plast;
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_merged <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_count  <= n_count;
            r_merged <= n_merged;
            r_ovalid <= n_ovalid;
        end
        r_i <= n_i;  r_j <= n_j;  r_addr <= n_addr;
        r_c <= n_c;  r_scr <= n_scr;  r_d <= n_d;  r_m <= n_m;
        r_ad <= n_ad;  r_am <= n_am;  r_as <= n_as;  r_touch <= n_touch;
        r_pst <= n_pst;  r_prect <= n_prect;  r_plast <= n_plast;
        r_ost <= n_ost;  r_ocnt <= n_ocnt;  r_orect <= n_orect;  r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[r_addr];
    end

endmodule

// File: design/dirty_rect_tracker_merger.sv
// ----------------------------------------------------------------------------
// dirty_rect_tracker_merger: dirty rectangle table with merge pass
// Tracks invalidated screen rectangles and lists them after merging.
// ----------------------------------------------------------------------------
// Items enter on the slave stream: tuser carries the action (add, clear,
// merge and list), tdata the rectangle. The front clips add rectangles to
// the screen and places each item in a two-entry queue; the back sequencer
// walks the table in a memory with one registered read port and drives the
// master stream through an output register. Every item gives one result,
// except merge, which lists every surviving rectangle and marks the final
// one with tlast.
// A clear, an off-screen add or an undefined action passes from the idle
// state through the output state to the output register; an add reads
// each stored rectangle in turn, and merge each examined pair and each
// listed rectangle, through the single table read port. Reset empties the
// table and sets a 320 by 240 screen. The user must write the screen size
// over the APB port (width at 0x0, height at 0x4) only while the block is
// idle; the block itself does not enforce this. When the receiver stalls
// the sequencer holds its next result, the queue fills, and tready falls.
// ----------------------------------------------------------------------------
module dirty_rect_tracker_merger import drtm_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,  // left, top, right, bottom
    input  logic [1:0]        s_axis_tuser,  // action
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // entry_count, left, top, right, bottom
    output logic [(($clog2(TABLE_DEPTH + 1) + 4 * COORD_BITS + 7) / 8) * 8 - 1:0]
                              m_axis_tdata,
    output logic [2:0]        m_axis_tuser,  // status
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_DW = ((CNT_W + 4 * COORD_BITS + 7) / 8) * 8;
    localparam int CMD_W = 6 * COORD_BITS + CTL_W;
    localparam int CB = COORD_BITS;

    logic [12:0]      r_screen_width, r_screen_height;
    logic [CMD_W-1:0] front_cmd, queue_cmd;
    logic             queue_full, queue_valid, queue_pop;
    logic [CNT_W-1:0] res_count;
    logic [4*CB-1:0]  res_rect;

    // Configuration registers; a write lands in the access cycle.
    assign pready = 1'b1;
    assign prdata = {19'd0, paddr[2] ? r_screen_height : r_screen_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= 13'd320;
            r_screen_height <= 13'd240;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) r_screen_height <= pwdata[12:0];
            else          r_screen_width  <= pwdata[12:0];
        end
    end

    assign s_axis_tready = !queue_full;

    drtm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_action        (s_axis_tuser),
        .i_left          (s_axis_tdata[15:0]),
        .i_top           (s_axis_tdata[31:16]),
        .i_right         (s_axis_tdata[47:32]),
        .i_bottom        (s_axis_tdata[63:48]),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_cmd           (front_cmd)
    );

    drtm_queue #(.WIDTH(CMD_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && s_axis_tready),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    drtm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_count     (res_count),
        .o_rect      (res_rect),
        .o_last      (m_axis_tlast)
    );

    // The table packs {x1, y1, x2, y2}; the stream puts the entry count lowest, then left.
    assign m_axis_tdata = OUT_DW'({res_rect[CB-1:0], res_rect[2*CB-1:CB],
                                   res_rect[3*CB-1:2*CB], res_rect[4*CB-1:3*CB],
                                   res_count});

endmodule
